/* rtl/core/smsg_pkg.sv */
// Package for the sliding median sharpness gate.
// Holds field widths, register indexes, reset values and parameter defaults.
// No dependencies.
package smsg_pkg;
   localparam int DEF_MAX_HALF_WINDOW = 31;
   localparam int DEF_SCORE_BITS      = 32;
   localparam int DEF_INDEX_BITS      = 20;

   localparam int FRAME_INDEX_BITS = 20;
   localparam int HW_BITS          = 5;
   localparam int TOL_BITS         = 7;
   localparam int CSR_INDEX_BITS   = 4;
   localparam int CSR_DATA_BITS    = 8;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HALF_WINDOW = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TOLERANCE   = 4'd1;

   localparam logic [HW_BITS-1:0]  HW_RESET  = 5'd5;
   localparam logic [TOL_BITS-1:0] TOL_RESET = 7'd10;
   localparam logic [TOL_BITS-1:0] TOL_MAX   = 7'd100;

   // Scale factors of the cross-multiplied threshold test.
   localparam int KEEP_SCALE = 2000;
   localparam int TOL_FULL   = 1000;
endpackage

/* rtl/core/smsg_ifaces.sv */
// Channel interfaces of the sliding median sharpness gate.
// Depends on smsg_pkg for the field widths.
interface smsg_req_if
   import smsg_pkg::*;
#(
   parameter int SCORE_BITS = DEF_SCORE_BITS
);
   logic                  valid;
   logic                  ready;
   logic [SCORE_BITS-1:0] score;
   logic                  selected;
   logic                  last_frame;
   modport source (output valid, score, selected, last_frame, input ready);
   modport sink (input valid, score, selected, last_frame, output ready);
endinterface

interface smsg_rsp_if
   import smsg_pkg::*;
;
   logic                        valid;
   logic                        ready;
   logic [FRAME_INDEX_BITS-1:0] frame_index;
   logic                        keep;
   logic                        last_result;
   modport source (output valid, frame_index, keep, last_result, input ready);
   modport sink (input valid, frame_index, keep, last_result, output ready);
endinterface

interface smsg_csr_if
   import smsg_pkg::*;
;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/smsg_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module smsg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 63
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/core/smsg_queue.sv */
// Short job queue between the front and the back of the gate.
// No dependencies.
module smsg_queue #(
   parameter int WIDTH = 27,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int PW = $clog2(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      count_ff, count_in;

   assign full     = count_ff == (PW+1)'(DEPTH);
   assign empty    = count_ff == '0;
   assign pop_data = slot_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push && !full) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop && !empty) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if ((push && !full) && !(pop && !empty)) begin
         count_in = count_ff + 1'b1;
      end else if (!(push && !full) && (pop && !empty)) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage.
   always_ff @(posedge clock) begin
      if (push && !full) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

/* rtl/core/smsg_front.sv */
// Front of the gate: takes frames, writes the score ring, and issues judge jobs.
// Depends on smsg_pkg and the channel interfaces.
module smsg_front
   import smsg_pkg::*;
#(
   parameter int MAX_HALF_WINDOW = DEF_MAX_HALF_WINDOW,
   parameter int SCORE_BITS      = DEF_SCORE_BITS,
   parameter int INDEX_BITS      = DEF_INDEX_BITS,
   localparam int D              = 2 * MAX_HALF_WINDOW + 1,
   localparam int AW             = $clog2(D),
   localparam int FW             = $clog2(D + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   smsg_req_if.sink              req_chan,
   input  logic [HW_BITS-1:0]    hw_cfg,
   input  logic                  q_full,
   input  logic                  q_empty,
   input  logic                  back_idle,
   output logic                  ram_wr_en,
   output logic [AW-1:0]         ram_wr_addr,
   output logic [SCORE_BITS-1:0] ram_wr_data,
   output logic                  job_push,
   output logic [AW-1:0]         job_age,
   output logic [INDEX_BITS-1:0] job_index,
   output logic                  job_last,
   output logic [AW-1:0]         step_hw,
   output logic [FW-1:0]         step_fill,
   output logic [AW-1:0]         step_wp
);
   localparam logic FS_IDLE = 1'b0;
   localparam logic FS_WALK = 1'b1;

   logic                  state_ff, state_in;
   logic [AW-1:0]         wp_ff, wp_in;
   logic [FW-1:0]         fill_ff, fill_in;
   logic [INDEX_BITS-1:0] counter_ff, counter_in;
   logic [D-1:0]          sel_ff, sel_in;
   logic                  last_ff, last_in;
   logic [AW-1:0]         hw_ff, hw_in;
   logic [AW-1:0]         age_ff, age_in;
   logic [HW_BITS-1:0]    hw_min;
   logic [AW-1:0]         hw_eff;
   logic                  accept;
   logic                  due;
   logic                  want;
   logic                  advance;
   logic [D-1:0]          below_mask;
   logic [FW-1:0]         fill_m1;

   // Effective half window: zero counts as one, capped at the maximum.
   assign hw_min = (hw_cfg == '0) ? HW_BITS'(1) : hw_cfg;
   assign hw_eff = (32'(hw_min) > 32'(MAX_HALF_WINDOW)) ? AW'(MAX_HALF_WINDOW) : AW'(hw_min);

   assign req_chan.ready = (state_ff == FS_IDLE) && q_empty && back_idle;
   assign accept         = req_chan.valid && req_chan.ready;

   // A frame is judged when it sits half a window back, or at any age on a flush.
   assign due        = last_ff || ((age_ff == hw_ff) && (fill_ff > FW'(hw_ff)));
   assign want       = due && sel_ff[age_ff];
   assign job_push   = (state_ff == FS_WALK) && want && !q_full;
   assign advance    = !want || !q_full;
   assign below_mask = (D'(1) << age_ff) - D'(1);
   assign job_age    = age_ff;
   assign job_index  = counter_ff - INDEX_BITS'(1) - INDEX_BITS'(age_ff);
   assign job_last   = last_ff && ((sel_ff & below_mask) == '0);

   assign ram_wr_en   = accept;
   assign ram_wr_addr = wp_in;
   assign ram_wr_data = req_chan.score;
   assign step_hw     = hw_ff;
   assign step_fill   = fill_ff;
   assign step_wp     = wp_ff;

   // Ring bookkeeping on a new frame and the age walk afterwards.
   always_comb begin
      state_in   = state_ff;
      wp_in      = (wp_ff == AW'(D - 1)) ? '0 : wp_ff + 1'b1;
      fill_in    = fill_ff;
      counter_in = counter_ff;
      sel_in     = sel_ff;
      last_in    = last_ff;
      hw_in      = hw_ff;
      age_in     = age_ff;
      fill_m1    = '0;
      case (state_ff)
         FS_IDLE: begin
            if (accept) begin
               if (last_ff) begin
                  fill_in    = FW'(1);
                  counter_in = INDEX_BITS'(1);
                  sel_in     = {{(D - 1){1'b0}}, req_chan.selected};
               end else begin
                  fill_in    = (fill_ff == FW'(D)) ? fill_ff : fill_ff + 1'b1;
                  counter_in = counter_ff + 1'b1;
                  sel_in     = {sel_ff[D-2:0], req_chan.selected};
               end
               fill_m1  = fill_in - 1'b1;
               last_in  = req_chan.last_frame;
               hw_in    = hw_eff;
               age_in   = (fill_m1 < FW'(hw_eff)) ? AW'(fill_m1) : hw_eff;
               state_in = FS_WALK;
            end
         end
         FS_WALK: begin
            if (advance) begin
               if (!last_ff || (age_ff == '0)) begin
                  state_in = FS_IDLE;
               end else begin
                  age_in = age_ff - 1'b1;
               end
            end
         end
         default: state_in = FS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= FS_IDLE;
         wp_ff      <= AW'(D - 1);
         fill_ff    <= '0;
         counter_ff <= '0;
         sel_ff     <= '0;
         last_ff    <= 1'b0;
         hw_ff      <= '0;
         age_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         if (accept) begin
            wp_ff <= wp_in;
         end
         fill_ff    <= fill_in;
         counter_ff <= counter_in;
         sel_ff     <= sel_in;
         last_ff    <= last_in;
         hw_ff      <= hw_in;
         age_ff     <= age_in;
      end
   end
endmodule

/* rtl/core/smsg_back.sv */
// Back of the gate: finds the window median by rank counting and makes the decision.
// Depends on smsg_pkg and the channel interfaces; reads the score ring through its read port.
module smsg_back
   import smsg_pkg::*;
#(
   parameter int MAX_HALF_WINDOW = DEF_MAX_HALF_WINDOW,
   parameter int SCORE_BITS      = DEF_SCORE_BITS,
   parameter int INDEX_BITS      = DEF_INDEX_BITS,
   localparam int D              = 2 * MAX_HALF_WINDOW + 1,
   localparam int AW             = $clog2(D),
   localparam int FW             = $clog2(D + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_valid,
   input  logic [AW-1:0]         job_age,
   input  logic [INDEX_BITS-1:0] job_index,
   input  logic                  job_last,
   output logic                  job_pop,
   input  logic [AW-1:0]         step_hw,
   input  logic [FW-1:0]         step_fill,
   input  logic [AW-1:0]         step_wp,
   input  logic [TOL_BITS-1:0]   tol_cfg,
   output logic [AW-1:0]         ram_rd_addr,
   input  logic [SCORE_BITS-1:0] ram_rd_data,
   output logic                  idle,
   smsg_rsp_if.source            rsp_chan
);
   localparam int PW = SCORE_BITS + 11;

   localparam logic [3:0] BS_IDLE     = 4'd0;
   localparam logic [3:0] BS_SELF_RD  = 4'd1;
   localparam logic [3:0] BS_SELF_CAP = 4'd2;
   localparam logic [3:0] BS_I_RD     = 4'd3;
   localparam logic [3:0] BS_I_CAP    = 4'd4;
   localparam logic [3:0] BS_INNER    = 4'd5;
   localparam logic [3:0] BS_EVAL     = 4'd6;
   localparam logic [3:0] BS_MUL      = 4'd7;
   localparam logic [3:0] BS_OUT      = 4'd8;

   logic [3:0]                  state_ff, state_in;
   logic [AW-1:0]               age_ff;
   logic [INDEX_BITS-1:0]       index_ff;
   logic                        last_ff;
   logic [AW-1:0]               lo_ff, hi_ff, kh_ff, kl_ff;
   logic [AW-1:0]               i_ff, jn_ff;
   logic                        iss_done_ff, pend_ff;
   logic [FW-1:0]               cnt_lt_ff, cnt_le_ff;
   logic [SCORE_BITS-1:0]       vi_ff, self_ff, med_hi_ff, med_lo_ff;
   logic [PW-1:0]               prod_l_ff, prod_r_ff;
   logic                        zero_ff;
   logic                        rsp_valid_ff;
   logic [FRAME_INDEX_BITS-1:0] out_index_ff;
   logic                        out_keep_ff, out_last_ff;
   logic [AW-1:0]               lo_c, hi_c, ah_c;
   logic [FW-1:0]               fm1_c, n_c;
   logic [SCORE_BITS:0]         sum2_c;
   logic [TOL_BITS-1:0]         tol_c;
   logic [9:0]                  factor_c;
   logic [31:0]                 idx32_c;
   logic                        out_free;

   // Ring address of a frame at a given age, counted back from the newest entry.
   function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] age);
      logic [AW:0] diff;
      diff = {1'b0, step_wp} - {1'b0, age};
      if (diff[AW]) begin
         diff = diff + (AW + 1)'(D);
      end
      return diff[AW-1:0];
   endfunction

   // Window bounds of a new job, clipped at the start and end of the sequence.
   assign lo_c  = (job_age > step_hw) ? job_age - step_hw : '0;
   assign ah_c  = job_age + step_hw;
   assign fm1_c = step_fill - 1'b1;
   assign hi_c  = (FW'(ah_c) > fm1_c) ? AW'(fm1_c) : ah_c;
   assign n_c   = FW'(hi_c) - FW'(lo_c) + 1'b1;

   assign idle     = state_ff == BS_IDLE;
   assign job_pop  = idle && job_valid;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign sum2_c   = {1'b0, med_hi_ff} + {1'b0, med_lo_ff};
   assign tol_c    = (tol_cfg > TOL_MAX) ? TOL_MAX : tol_cfg;
   assign factor_c = 10'(TOL_FULL) - 10'(tol_c);
   assign idx32_c  = 32'(index_ff);

   // Read address follows the sequencer.
   always_comb begin
      case (state_ff)
         BS_SELF_RD: ram_rd_addr = ring_addr(age_ff);
         BS_I_RD:    ram_rd_addr = ring_addr(i_ff);
         default:    ram_rd_addr = ring_addr(jn_ff);
      endcase
   end

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BS_IDLE:     if (job_valid) state_in = BS_SELF_RD;
         BS_SELF_RD:  state_in = BS_SELF_CAP;
         BS_SELF_CAP: state_in = BS_I_RD;
         BS_I_RD:     state_in = BS_I_CAP;
         BS_I_CAP:    state_in = BS_INNER;
         BS_INNER:    if (iss_done_ff) state_in = BS_EVAL;
         BS_EVAL:     state_in = (i_ff == hi_ff) ? BS_MUL : BS_I_RD;
         BS_MUL:      state_in = BS_OUT;
         BS_OUT:      if (out_free) state_in = BS_IDLE;
         default:     state_in = BS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BS_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if ((state_ff == BS_OUT) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath: rank counting for each window entry, then the threshold test.
   always_ff @(posedge clock) begin
      case (state_ff)
         BS_IDLE: begin
            age_ff   <= job_age;
            index_ff <= job_index;
            last_ff  <= job_last;
            lo_ff    <= lo_c;
            hi_ff    <= hi_c;
            kh_ff    <= AW'(n_c >> 1);
            kl_ff    <= n_c[0] ? AW'(n_c >> 1) : AW'((n_c >> 1) - 1'b1);
         end
         BS_SELF_CAP: begin
            self_ff <= ram_rd_data;
            i_ff    <= lo_ff;
         end
         BS_I_CAP: begin
            vi_ff       <= ram_rd_data;
            jn_ff       <= lo_ff;
            iss_done_ff <= 1'b0;
            pend_ff     <= 1'b0;
            cnt_lt_ff   <= '0;
            cnt_le_ff   <= '0;
         end
         BS_INNER: begin
            if (pend_ff) begin
               if (ram_rd_data < vi_ff) begin
                  cnt_lt_ff <= cnt_lt_ff + 1'b1;
               end
               if (ram_rd_data <= vi_ff) begin
                  cnt_le_ff <= cnt_le_ff + 1'b1;
               end
            end
            pend_ff <= !iss_done_ff;
            if (!iss_done_ff) begin
               jn_ff       <= jn_ff + 1'b1;
               iss_done_ff <= jn_ff == hi_ff;
            end
         end
         BS_EVAL: begin
            if ((cnt_lt_ff <= FW'(kh_ff)) && (FW'(kh_ff) < cnt_le_ff)) begin
               med_hi_ff <= vi_ff;
            end
            if ((cnt_lt_ff <= FW'(kl_ff)) && (FW'(kl_ff) < cnt_le_ff)) begin
               med_lo_ff <= vi_ff;
            end
            i_ff <= i_ff + 1'b1;
         end
         BS_MUL: begin
            zero_ff   <= sum2_c == '0;
            prod_l_ff <= PW'(self_ff) * PW'(KEEP_SCALE);
            prod_r_ff <= PW'(sum2_c) * PW'(factor_c);
         end
         BS_OUT: begin
            if (out_free) begin
               out_index_ff <= idx32_c[FRAME_INDEX_BITS-1:0];
               out_keep_ff  <= zero_ff || (prod_l_ff >= prod_r_ff);
               out_last_ff  <= last_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.frame_index = out_index_ff;
   assign rsp_chan.keep        = out_keep_ff;
   assign rsp_chan.last_result = out_last_ff;
endmodule

/* rtl/core/sliding_median_sharpness_gate.sv */
// Sliding median sharpness gate: top level with configuration registers.
// A new frame waits until all judgements are done.
// Each judgement ranks every entry of its clipped window, up to 2*half_window+1 entries,
// against the others on the single ring read port.
// Results leave through one output register.
// Synchronous reset clears control state and restores half_window 5, tolerance 10.
module sliding_median_sharpness_gate
   import smsg_pkg::*;
#(
   parameter int MAX_HALF_WINDOW = DEF_MAX_HALF_WINDOW,
   parameter int SCORE_BITS      = DEF_SCORE_BITS,
   parameter int INDEX_BITS      = DEF_INDEX_BITS
) (
   input  logic        clock,
   input  logic        reset,
   smsg_req_if.sink    req_chan,
   smsg_rsp_if.source  rsp_chan,
   smsg_csr_if.sink    csr_chan
);
   localparam int D  = 2 * MAX_HALF_WINDOW + 1;
   localparam int AW = $clog2(D);
   localparam int FW = $clog2(D + 1);
   localparam int JW = AW + INDEX_BITS + 1;

   logic [HW_BITS-1:0]    hw_ff;
   logic [TOL_BITS-1:0]   tol_ff;
   logic                  ram_wr_en;
   logic [AW-1:0]         ram_wr_addr, ram_rd_addr;
   logic [SCORE_BITS-1:0] ram_wr_data, ram_rd_data;
   logic                  job_push, job_pop, q_full, q_empty, back_idle;
   logic [AW-1:0]         push_age, pop_age;
   logic [INDEX_BITS-1:0] push_index, pop_index;
   logic                  push_last, pop_last;
   logic [AW-1:0]         step_hw, step_wp;
   logic [FW-1:0]         step_fill;

   // Configuration registers; writes are always taken.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hw_ff  <= HW_RESET;
         tol_ff <= TOL_RESET;
      end else if (csr_chan.valid) begin
         if (csr_chan.index == CSR_HALF_WINDOW) begin
            hw_ff <= csr_chan.data[HW_BITS-1:0];
         end else if (csr_chan.index == CSR_TOLERANCE) begin
            tol_ff <= csr_chan.data[TOL_BITS-1:0];
         end
      end
   end

   smsg_ram #(.WIDTH(SCORE_BITS), .DEPTH(D)) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   smsg_front #(
      .MAX_HALF_WINDOW (MAX_HALF_WINDOW),
      .SCORE_BITS      (SCORE_BITS),
      .INDEX_BITS      (INDEX_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .hw_cfg      (hw_ff),
      .q_full      (q_full),
      .q_empty     (q_empty),
      .back_idle   (back_idle),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .job_push    (job_push),
      .job_age     (push_age),
      .job_index   (push_index),
      .job_last    (push_last),
      .step_hw     (step_hw),
      .step_fill   (step_fill),
      .step_wp     (step_wp)
   );

   smsg_queue #(.WIDTH(JW), .DEPTH(4)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data ({push_age, push_index, push_last}),
      .full      (q_full),
      .pop       (job_pop),
      .pop_data  ({pop_age, pop_index, pop_last}),
      .empty     (q_empty)
   );

   smsg_back #(
      .MAX_HALF_WINDOW (MAX_HALF_WINDOW),
      .SCORE_BITS      (SCORE_BITS),
      .INDEX_BITS      (INDEX_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (!q_empty),
      .job_age     (pop_age),
      .job_index   (pop_index),
      .job_last    (pop_last),
      .job_pop     (job_pop),
      .step_hw     (step_hw),
      .step_fill   (step_fill),
      .step_wp     (step_wp),
      .tol_cfg     (tol_ff),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .idle        (back_idle),
      .rsp_chan    (rsp_chan)
   );
endmodule
